/* sv/jse_pkg.sv */
package jse_pkg;

    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_PAIR    = 2'd1,
        KIND_UNICODE = 2'd2
    } kind_t;

    // One classified item as it waits between front and back.
    // unit holds the unit itself for plain and unicode items,
    // and the character after the backslash for pair items.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] unit;
        logic        string_end;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_SQUOTE    = 16'h0027;
    localparam logic [15:0] CH_DQUOTE    = 16'h0022;
    localparam logic [15:0] CH_BACKTICK  = 16'h0060;
    localparam logic [15:0] CH_DOLLAR    = 16'h0024;
    localparam logic [15:0] CH_LF        = 16'h000A;
    localparam logic [15:0] CH_CR        = 16'h000D;
    localparam logic [15:0] CH_TAB       = 16'h0009;
    localparam logic [15:0] CH_N         = 16'h006E;
    localparam logic [15:0] CH_R         = 16'h0072;
    localparam logic [15:0] CH_T         = 16'h0074;
    localparam logic [15:0] CH_U         = 16'h0075;
    localparam logic [15:0] CH_DIGIT_0   = 16'h0030;
    localparam logic [15:0] CH_DIGIT_9   = 16'h0039;
    localparam logic [15:0] CH_LOWER_A   = 16'h0061;
    localparam logic [15:0] CH_LOWER_F   = 16'h0066;
    localparam logic [15:0] CTRL_LIMIT   = 16'h0020;
    localparam logic [15:0] LINE_SEP     = 16'h2028;
    localparam logic [15:0] PARA_SEP     = 16'h2029;

    // Position within the run of results for one item
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIRST   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SECOND  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_HEX_0   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_HEX_1   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_HEX_2   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_HEX_3   = 3'd5;

endpackage

/* sv/jse_front.sv */
module jse_front
    import jse_pkg::*;
(
    input  logic [15:0] code_unit,
    input  logic        string_end,
    input  logic        push,
    input  q_status_t   q_status,
    output logic        full,
    output logic        q_wr,
    output cmd_t        q_wr_data
);

    // Classify the incoming unit into the kind of escape it needs
    always_comb
    begin
        q_wr_data.string_end = string_end;
        q_wr_data.unit       = code_unit;
        q_wr_data.kind       = KIND_PLAIN;
        priority if (code_unit == CH_BACKSLASH || code_unit == CH_SQUOTE ||
                     code_unit == CH_DQUOTE || code_unit == CH_BACKTICK ||
                     code_unit == CH_DOLLAR)
        begin
            q_wr_data.kind = KIND_PAIR;
        end
        else if (code_unit == CH_LF)
        begin
            q_wr_data.kind = KIND_PAIR;
            q_wr_data.unit = CH_N;
        end
        else if (code_unit == CH_CR)
        begin
            q_wr_data.kind = KIND_PAIR;
            q_wr_data.unit = CH_R;
        end
        else if (code_unit == CH_TAB)
        begin
            q_wr_data.kind = KIND_PAIR;
            q_wr_data.unit = CH_T;
        end
        else if (code_unit < CTRL_LIMIT || code_unit == LINE_SEP ||
                 code_unit == PARA_SEP)
        begin
            q_wr_data.kind = KIND_UNICODE;
        end
        else
        begin
            q_wr_data.kind = KIND_PLAIN;
        end
    end

    assign full = q_status.full;
    assign q_wr = push && !q_status.full;

endmodule

/* sv/jse_queue.sv */
module jse_queue
    import jse_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  cmd_t      wr_data,
    input  logic      rd,
    output cmd_t      rd_data,
    output q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({wr, rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);

endmodule

/* sv/jse_back.sv */
module jse_back
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  q_status_t   q_status,
    output logic        q_rd,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] out_unit,
    output logic        run_last,
    output logic        string_done
);

    function automatic logic [15:0] hex_char(input logic [3:0] nib);
        logic [15:0] wide;
        wide = {12'd0, nib};
        return (nib < 4'd10) ? (CH_DIGIT_0 + wide) : (CH_LOWER_A + wide - 16'd10);
    endfunction

    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic [15:0]       unit_reg;
    logic              last_reg;
    logic              done_reg;

    logic        advance;
    logic        load;
    logic [15:0] cur_unit;
    logic        cur_last;
    logic [3:0]  nib;

    // Output register frees up when empty or being popped
    assign advance = !valid_reg || pop;
    assign load    = advance && !q_status.empty;

    always_comb
    begin
        unique case (step_reg)
            STEP_HEX_0: nib = head.unit[15:12];
            STEP_HEX_1: nib = head.unit[11:8];
            STEP_HEX_2: nib = head.unit[7:4];
            default:    nib = head.unit[3:0];
        endcase
    end

    always_comb
    begin
        cur_unit = head.unit;
        cur_last = 1'b1;
        unique case (head.kind)
            KIND_PAIR:
            begin
                cur_last = (step_reg == STEP_SECOND);
                cur_unit = (step_reg == STEP_FIRST) ? CH_BACKSLASH : head.unit;
            end
            KIND_UNICODE:
            begin
                cur_last = (step_reg == STEP_HEX_3);
                if (step_reg == STEP_FIRST)
                begin
                    cur_unit = CH_BACKSLASH;
                end
                else if (step_reg == STEP_SECOND)
                begin
                    cur_unit = CH_U;
                end
                else
                begin
                    cur_unit = hex_char(nib);
                end
            end
            default:
            begin
                cur_unit = head.unit;
                cur_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            step_next  = cur_last ? STEP_FIRST : step_reg + 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    assign q_rd = load && cur_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= cur_unit;
            last_reg <= cur_last;
            done_reg <= cur_last && head.string_end;
        end
    end

    assign empty       = !valid_reg;
    assign out_unit    = unit_reg;
    assign run_last    = last_reg;
    assign string_done = done_reg;

endmodule

/* sv/js_string_escaper.sv */
// Escapes UTF-16 text for a JavaScript string literal, one code unit per item.
//
// Input queue port: present code_unit and string_end with push; the item is
// taken at a clock edge where push is high and full is low. full rises only
// when the internal command queue (QUEUE_DEPTH entries) has no free slot.
//
// Result queue port: while empty is low, out_unit, run_last and string_done
// show the oldest result; pop at an edge with empty low takes it. run_last
// marks the final unit of each item's run; string_done is set on that unit
// when the item carried string_end.
//
// A taken item is written into a queue slot, then loaded into the output register,
// which shows its first result. Throughput: while the receiver pops, the back
// sequencer emits one unit per cycle and plain text streams at one item per cycle;
// an item yields 1 unit (plain), 2 units (backslash pair) or 6 units (\uXXXX form).
//
// Reset (rst_n low, asynchronous) drops the queue contents and any result
// waiting at the output. A stalled receiver holds the output register; the
// queue keeps taking items until it fills, then full holds the sender.
module js_string_escaper
    import jse_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        string_end,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] out_unit,
    output logic        run_last,
    output logic        string_done
);

    cmd_t      q_wr_data;
    cmd_t      q_head;
    q_status_t q_status;
    logic      q_wr;
    logic      q_rd;

    // Front: classify each item as plain, backslash pair or unicode escape
    jse_front u_front (
        .code_unit  (code_unit),
        .string_end (string_end),
        .push       (push),
        .q_status   (q_status),
        .full       (full),
        .q_wr       (q_wr),
        .q_wr_data  (q_wr_data)
    );

    // Hold classified items so front and back can stall on their own
    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_head),
        .status  (q_status)
    );

    // Back: step through the escape sequence, one unit per cycle unless the receiver stalls
    jse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_status    (q_status),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .out_unit    (out_unit),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

/* sv/jse_checker.sv */
module jse_checker
    import jse_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [15:0] code_unit,
    input logic        string_end,
    input logic        empty,
    input logic        pop,
    input logic [15:0] out_unit,
    input logic        run_last,
    input logic        string_done
);

    // A waiting item is held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_unit) && $stable(run_last) &&
                              $stable(string_done)))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && string_done) |-> run_last)
        else $error("string_done without run_last");

    // Only backslash, 'u' or hex digits appear before the end of a run
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !run_last) |->
            (out_unit == CH_BACKSLASH || out_unit == CH_U ||
             (out_unit >= CH_DIGIT_0 && out_unit <= CH_DIGIT_9) ||
             (out_unit >= CH_LOWER_A && out_unit <= CH_LOWER_F)))
        else $error("unexpected unit inside an escape");

    // A taken item leaves a result on the output once it has passed the queue and the output register
    a_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> ##2 !empty)
        else $error("no result after a taken item");

    // A taken item carries known fields
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |-> !$isunknown({code_unit, string_end}))
        else $error("unknown field on a taken item");

endmodule

bind js_string_escaper jse_checker u_jse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .code_unit   (code_unit),
    .string_end  (string_end),
    .empty       (empty),
    .pop         (pop),
    .out_unit    (out_unit),
    .run_last    (run_last),
    .string_done (string_done)
);
